// ----- rtl/per_client_fixed_window_rate_limiter_unit_macros.svh -----
// assertion helpers shared by the rate limiter rtl
`ifndef PER_CLIENT_FIXED_WINDOW_RATE_LIMITER_UNIT_MACROS_SVH
`define PER_CLIENT_FIXED_WINDOW_RATE_LIMITER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define PCFWRL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define PCFWRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/pcfwrl_pkg.sv -----
package pcfwrl_pkg;

  // field widths
  localparam int OP_W       = 3;
  localparam int SLOT_W     = 6;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 17;
  localparam int MAX_W      = 16;
  localparam int WIN_W      = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  // register reset values and count ceiling
  localparam logic [MAX_W-1:0]   MAX_RESET    = 16'd100;
  localparam logic [WIN_W-1:0]   WINDOW_RESET = 31'd60;
  localparam logic [COUNT_W-1:0] COUNT_SAT    = 17'd65536;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUESTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_REQUEST = 3'd0,
    OP_BLOCK   = 3'd1,
    OP_UNBLOCK = 3'd2,
    OP_QUERY   = 3'd3,
    OP_CLEANUP = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP_RD,
    ST_SWEEP_WR,
    ST_SWEEP_DONE
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  last_time;
    logic               blocked;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep_rd;
    logic sweep_wr;
    logic clear_wr;
    logic cnt_clr;
    logic cnt_inc;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_cleanup;
    logic cnt_last;
  } dp_status_t;

endpackage

// ----- rtl/pcfwrl_if.sv -----
// input item channel
interface pcfwrl_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [5:0] client_index;
  logic [31:0] now_time;

  modport source (output valid, output req_type, output client_index, output now_time,
                  input ready);
  modport sink (input valid, input req_type, input client_index, input now_time,
                output ready);
endinterface

// result item channel
interface pcfwrl_rsp_if;
  logic        valid;
  logic        ready;
  logic        allowed;
  logic        client_blocked;
  logic        limit_exceeded;
  logic [16:0] request_count;

  modport source (output valid, output allowed, output client_blocked,
                  output limit_exceeded, output request_count, input ready);
  modport sink (input valid, input allowed, input client_blocked,
                input limit_exceeded, input request_count, output ready);
endinterface

// ----- rtl/pcfwrl_datapath.sv -----
module pcfwrl_datapath #(
  parameter int CLIENTS = 64
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  pcfwrl_pkg::dp_cmd_t                     cmd,
  output pcfwrl_pkg::dp_status_t                  status,
  input  logic [pcfwrl_pkg::OP_W-1:0]             req_type,
  input  logic [pcfwrl_pkg::SLOT_W-1:0]           client_index,
  input  logic [pcfwrl_pkg::TIME_W-1:0]           now_time,
  input  logic                                    cfg_we,
  input  logic [pcfwrl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pcfwrl_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                    allowed,
  output logic                                    client_blocked,
  output logic                                    limit_exceeded,
  output logic [pcfwrl_pkg::COUNT_W-1:0]          request_count
);
  import pcfwrl_pkg::*;

  localparam int IW = $clog2(CLIENTS);
  localparam int XW = IW + SLOT_W;

  logic [MAX_W-1:0]   max_requests;
  logic [WIN_W-1:0]   window_ticks;
  op_t                op_q;
  logic [IW-1:0]      slot_q;
  logic               in_range_q;
  logic [TIME_W-1:0]  now_q;
  logic [IW-1:0]      cnt;
  logic [XW-1:0]      idx_wide;
  logic [IW-1:0]      rd_addr;
  entry_t             rd_data;
  entry_t             mem [CLIENTS];
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  entry_t             wr_data;
  logic [TIME_W-1:0]  idle;
  logic               win_expired;
  logic               sweep_expired;
  logic [COUNT_W-1:0] base_count;
  logic [COUNT_W-1:0] inc_count;
  logic               over_limit;
  entry_t             new_entry;
  logic               exec_we;
  logic               res_allowed;
  logic               res_blocked;
  logic               res_exceeded;
  logic [COUNT_W-1:0] res_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_requests <= MAX_RESET;
      window_ticks <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_REQUESTS: max_requests <= cfg_data[MAX_W-1:0];
        CFG_WINDOW_TICKS: window_ticks <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // slot index widened to the table size
  assign idx_wide = {{IW{1'b0}}, client_index};

  // item capture on transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q       <= op_t'(req_type);
      slot_q     <= idx_wide[IW-1:0];
      in_range_q <= (idx_wide < XW'(CLIENTS));
      now_q      <= now_time;
    end
  end

  // sweep and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign status.is_cleanup = (op_t'(req_type) == OP_CLEANUP);
  assign status.cnt_last   = (cnt == IW'(CLIENTS - 1));

  // client table, registered read
  assign rd_addr = cmd.sweep_rd ? cnt : idx_wide[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture || cmd.sweep_rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // elapsed time and window checks
  assign idle          = now_q - rd_data.last_time;
  assign win_expired   = (idle > {1'b0, window_ticks});
  assign sweep_expired = (idle > {window_ticks, 1'b0});
  assign base_count    = win_expired ? '0 : rd_data.count;
  assign inc_count     = (base_count < COUNT_SAT) ? base_count + 1'b1 : base_count;
  assign over_limit    = (inc_count > {1'b0, max_requests});

  // per-operation update and result
  always_comb begin
    new_entry    = rd_data;
    exec_we      = 1'b0;
    res_allowed  = 1'b0;
    res_blocked  = 1'b0;
    res_exceeded = 1'b0;
    res_count    = '0;
    if (in_range_q) begin
      case (op_q)
        OP_REQUEST: begin
          if (!rd_data.blocked) begin
            new_entry.count     = inc_count;
            new_entry.last_time = now_q;
            exec_we             = 1'b1;
            res_allowed         = !over_limit;
            res_exceeded        = over_limit;
          end
          res_blocked = rd_data.blocked;
          res_count   = new_entry.count;
        end
        OP_BLOCK: begin
          new_entry.blocked = 1'b1;
          exec_we           = 1'b1;
          res_blocked       = 1'b1;
          res_count         = rd_data.count;
        end
        OP_UNBLOCK: begin
          new_entry.blocked = 1'b0;
          exec_we           = 1'b1;
          res_count         = rd_data.count;
        end
        OP_QUERY: begin
          res_blocked = rd_data.blocked;
          res_count   = rd_data.count;
        end
        default: ;
      endcase
    end
  end

  // table write select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = '0;
    if (cmd.clear_wr || (cmd.sweep_wr && sweep_expired)) begin
      wr_en = 1'b1;
    end else if (cmd.exec && exec_we) begin
      wr_en   = 1'b1;
      wr_addr = slot_q;
      wr_data = new_entry;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      allowed        <= res_allowed;
      client_blocked <= res_blocked;
      limit_exceeded <= res_exceeded;
      request_count  <= res_count;
    end
  end

endmodule

// ----- rtl/pcfwrl_ctrl.sv -----
module pcfwrl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  pcfwrl_pkg::dp_status_t status,
  output pcfwrl_pkg::dp_cmd_t    cmd
);
  import pcfwrl_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = status.is_cleanup ? ST_SWEEP_RD : ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_SWEEP_RD: state_next = ST_SWEEP_WR;
      ST_SWEEP_WR: begin
        state_next = status.cnt_last ? ST_SWEEP_DONE : ST_SWEEP_RD;
      end
      ST_SWEEP_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        cmd.cnt_clr = in_valid;
      end
      ST_EXEC: begin
        cmd.exec     = out_free;
        cmd.load_out = out_free;
      end
      ST_SWEEP_RD: cmd.sweep_rd = 1'b1;
      ST_SWEEP_WR: begin
        cmd.sweep_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
      end
      ST_SWEEP_DONE: cmd.load_out = out_free;
      default: ;
    endcase
  end

endmodule

// ----- rtl/per_client_fixed_window_rate_limiter_unit.sv -----
// Per-client fixed-window rate limiter over a table of CLIENTS entries. Items are handled
// one at a time: request, block, unblock and query each take a registered read of the
// client's table entry, then the read-modify-write and result load, which wait while the
// result register is still full; no new item is taken until that load. Cleanup walks the
// whole table through its single port, a read and then a write for each entry, then loads
// its result; no item is taken meanwhile. After reset a clearing pass zeroes the table
// before the first item is taken; configuration writes are taken at any time
// and should be made only while the block is idle.
`include "per_client_fixed_window_rate_limiter_unit_macros.svh"

module per_client_fixed_window_rate_limiter_unit #(
  parameter int CLIENTS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  pcfwrl_req_if.sink                        req,
  pcfwrl_rsp_if.source                      rsp,
  input  logic                              cfg_we,
  input  logic [pcfwrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcfwrl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcfwrl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  pcfwrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // table, config and result datapath
  pcfwrl_datapath #(
    .CLIENTS (CLIENTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .req_type       (req.req_type),
    .client_index   (req.client_index),
    .now_time       (req.now_time),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .allowed        (rsp.allowed),
    .client_blocked (rsp.client_blocked),
    .limit_exceeded (rsp.limit_exceeded),
    .request_count  (rsp.request_count)
  );

  // checks
  `PCFWRL_ASSERT_NEXT(a_one_item_at_a_time, req.valid && req.ready, !req.ready, "item taken while busy")
  `PCFWRL_ASSERT_NOW(a_no_result_overwrite, cmd.load_out, !rsp.valid || rsp.ready, "result overwritten before transfer")
  `PCFWRL_ASSERT_NOW(a_no_intake_in_clear, cmd.clear_wr, !req.ready, "item taken during clearing pass")

endmodule

// ----- tb/sv/tb_per_client_fixed_window_rate_limiter_unit.sv -----
`timescale 1ns / 100ps

module tb_per_client_fixed_window_rate_limiter_unit;
  import pcfwrl_pkg::*;

  localparam int CLIENTS = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 2 * CLIENTS + 8;

  // opcodes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic               allowed;
    logic               blocked;
    logic               exceeded;
    logic [COUNT_W-1:0] count;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcfwrl_req_if req_ch ();
  pcfwrl_rsp_if rsp_ch ();

  per_client_fixed_window_rate_limiter_unit #(
    .CLIENTS(CLIENTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // shadow client table and limits
  logic [COUNT_W-1:0] tbl_count [CLIENTS];
  logic [TIME_W-1:0]  tbl_stamp [CLIENTS];
  logic               tbl_blocked [CLIENTS];
  logic [MAX_W-1:0]   lim_max;
  logic [WIN_W-1:0]   lim_window;

  verdict_t pending_verdicts [$];

  bit back_to_back = 1'b0;
  int mismatches = 0;
  int results_checked = 0;
  int items_sent = 0;
  int n_admitted = 0;
  int n_over = 0;
  int n_sweeps = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  // expected outcome of one item, updating the shadow table
  function automatic verdict_t judge_item(input logic [OP_W-1:0] op,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [TIME_W-1:0] now);
    verdict_t v;
    logic [TIME_W-1:0] idle;
    logic [TIME_W:0] sweep_span;
    logic known;
    int s;
    v = '0;
    known = 1'b1;
    sweep_span = {1'b0, lim_window, 1'b0};
    case (op)
      OP_CLEANUP: begin
        for (s = 0; s < CLIENTS; s++) begin
          idle = now - tbl_stamp[s];
          if ({1'b0, idle} > sweep_span) begin
            tbl_count[s] = '0;
            tbl_stamp[s] = '0;
            tbl_blocked[s] = 1'b0;
          end
        end
      end
      OP_REQUEST: begin
        if (!tbl_blocked[slot]) begin
          idle = now - tbl_stamp[slot];
          if (idle > {1'b0, lim_window}) tbl_count[slot] = '0;
          if (tbl_count[slot] < COUNT_SAT) tbl_count[slot] = tbl_count[slot] + 1'b1;
          tbl_stamp[slot] = now;
          if (tbl_count[slot] > {1'b0, lim_max}) v.exceeded = 1'b1;
          else v.allowed = 1'b1;
        end
      end
      OP_BLOCK:   tbl_blocked[slot] = 1'b1;
      OP_UNBLOCK: tbl_blocked[slot] = 1'b0;
      OP_QUERY:   ;
      default:    known = 1'b0;
    endcase
    if (known && op != OP_CLEANUP) begin
      v.blocked = tbl_blocked[slot];
      v.count = tbl_count[slot];
    end
    return v;
  endfunction

  // one item: random gap, hold valid until the transfer, then predict
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                           input logic [TIME_W-1:0] now);
    int gap;
    verdict_t v;
    gap = back_to_back ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= op;
    req_ch.client_index <= slot;
    req_ch.now_time <= now;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    v = judge_item(op, slot, now);
    pending_verdicts.push_back(v);
    items_sent++;
    if (v.allowed) n_admitted++;
    if (v.exceeded) n_over++;
    if (op == OP_CLEANUP) n_sweeps++;
  endtask

  // let the block drain before touching the registers
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_REQUESTS) lim_max = data[MAX_W-1:0];
    else lim_window = data[WIN_W-1:0];
  endtask

  task automatic set_limits(input logic [MAX_W-1:0] max_req, input logic [WIN_W-1:0] win);
    settle();
    write_reg(CFG_MAX_REQUESTS, {15'd0, max_req});
    write_reg(CFG_WINDOW_TICKS, win);
    settings_used++;
  endtask

  // every operation under the reset limits, window edges and sweeps
  task automatic test_basic_ops();
    int k;
    send_item(OP_QUERY, 6'd0, 32'd0);
    send_item(OP_REQUEST, 6'd0, 32'd0);
    // elapsed equal to the window keeps the count
    send_item(OP_REQUEST, 6'd0, 32'd60);
    send_item(OP_REQUEST, 6'd0, 32'd121);
    // blocked client is refused without counting
    send_item(OP_BLOCK, 6'd5, 32'd0);
    send_item(OP_REQUEST, 6'd5, 32'd7);
    send_item(OP_QUERY, 6'd5, 32'd7);
    send_item(OP_UNBLOCK, 6'd5, 32'd8);
    send_item(OP_REQUEST, 6'd5, 32'd8);
    for (k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
      send_item(3'(k), 6'd63, 32'hFFFF_FFFF);
    // elapsed time across the wrap of the clock
    send_item(OP_REQUEST, 6'd63, 32'hFFFF_FFFF);
    send_item(OP_REQUEST, 6'd63, 32'h0000_0010);
    send_item(OP_REQUEST, 6'd7, 32'h0000_0100);
    send_item(OP_BLOCK, 6'd7, 32'h0000_0100);
    // idle exactly twice the window survives, one tick more is cleared
    send_item(OP_CLEANUP, 6'h2A, 32'h0000_0178);
    send_item(OP_QUERY, 6'd7, 32'h0000_0178);
    send_item(OP_CLEANUP, 6'h15, 32'h0000_0179);
    send_item(OP_QUERY, 6'd7, 32'h0000_0179);
  endtask

  // zero limits, zero window and the widest window
  task automatic test_limit_extremes();
    set_limits(16'd0, 31'd0);
    send_item(OP_REQUEST, 6'd1, 32'hA5A5_5A5A);
    send_item(OP_REQUEST, 6'd1, 32'hA5A5_5A5A);
    set_limits(16'd1, 31'd0);
    send_item(OP_REQUEST, 6'd2, 32'h5A5A_A5A5);
    send_item(OP_REQUEST, 6'd2, 32'h5A5A_A5A5);
    send_item(OP_REQUEST, 6'd2, 32'h5A5A_A5A6);
    set_limits(16'd2, 31'h7FFF_FFFF);
    send_item(OP_REQUEST, 6'd3, 32'h0000_0000);
    send_item(OP_REQUEST, 6'd4, 32'h0000_0001);
    send_item(OP_REQUEST, 6'd4, 32'h8000_0001);
    send_item(OP_CLEANUP, 6'd0, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 6'd3, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 6'd4, 32'hFFFF_FFFF);
  endtask

  // a burst with no gaps that runs one client well past its limit
  task automatic test_burst_over_limit();
    logic [TIME_W-1:0] t;
    t = $urandom;
    set_limits(16'd24, 31'h7FFF_FFFF);
    back_to_back = 1'b1;
    repeat (40) send_item(OP_REQUEST, 6'd9, t);
    send_item(OP_QUERY, 6'd9, t);
    back_to_back = 1'b0;
  endtask

  // phases of mostly well-formed traffic on a few busy clients
  task automatic test_random_traffic();
    int p;
    int i;
    int pick;
    logic [MAX_W-1:0] mx;
    logic [WIN_W-1:0] wn;
    logic [63:0] step;
    logic [TIME_W-1:0] stamp_now;
    logic [SLOT_W-1:0] hot [4];
    logic [SLOT_W-1:0] slot;
    logic [OP_W-1:0] op;
    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin mx = 16'd3; wn = 31'd50; end
        1: begin mx = '0; wn = '0; end
        2: begin mx = '1; wn = '1; end
        3: begin mx = 16'd1; wn = 31'd1; end
        default: begin
          mx = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
          wn = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 500));
        end
      endcase
      set_limits(mx, wn);
      back_to_back = (p % 3 == 2);
      for (i = 0; i < 4; i++) hot[i] = 6'($urandom_range(0, CLIENTS - 1));
      stamp_now = $urandom;
      for (i = 0; i < 190; i++) begin
        // advance the clock: same tick, inside the window, past it, or anywhere
        pick = $urandom_range(0, 99);
        if (pick < 40) step = 64'd0;
        else if (pick < 80) step = 64'($urandom_range(0, (wn < 4) ? 3 : wn / 4));
        else if (pick < 95) step = 64'(wn) + 64'd1 + 64'($urandom_range(0, wn));
        else begin
          stamp_now = $urandom;
          step = 64'd0;
        end
        stamp_now = stamp_now + step[TIME_W-1:0];
        slot = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, CLIENTS - 1))
                                           : hot[$urandom_range(0, 3)];
        pick = $urandom_range(0, 99);
        if (pick < 68) op = OP_REQUEST;
        else if (pick < 73) op = OP_BLOCK;
        else if (pick < 80) op = OP_UNBLOCK;
        else if (pick < 88) op = OP_QUERY;
        else if (pick < 94) op = OP_CLEANUP;
        else op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        send_item(op, slot, stamp_now);
      end
    end
    back_to_back = 1'b0;
  endtask

  // result side: random stalls, compare each transfer with the oldest prediction
  initial begin
    verdict_t got;
    verdict_t want;
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = back_to_back ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (rsp_ch.valid !== 1'b1) @(posedge clk);
      got.allowed = rsp_ch.allowed;
      got.blocked = rsp_ch.client_blocked;
      got.exceeded = rsp_ch.limit_exceeded;
      got.count = rsp_ch.request_count;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: allowed %0b blocked %0b exceeded %0b count %0d",
                   got.allowed, got.blocked, got.exceeded, got.count);
      end else begin
        want = pending_verdicts.pop_front();
        results_checked++;
        if (got.allowed !== want.allowed || got.blocked !== want.blocked ||
            got.exceeded !== want.exceeded || got.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected a/b/e/count %0b/%0b/%0b/%0d, got %0b/%0b/%0b/%0d",
                     results_checked, want.allowed, want.blocked, want.exceeded, want.count,
                     got.allowed, got.blocked, got.exceeded, got.count);
        end
      end
      @(negedge clk);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst === 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_verdicts.size());
      $display("FAIL per_client_fixed_window_rate_limiter_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset, tests in turn, drain and verdict
  initial begin
    int s;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.client_index = '0;
    req_ch.now_time = '0;
    lim_max = MAX_RESET;
    lim_window = WINDOW_RESET;
    for (s = 0; s < CLIENTS; s++) begin
      tbl_count[s] = '0;
      tbl_stamp[s] = '0;
      tbl_blocked[s] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_limit_extremes();
    test_burst_over_limit();
    test_random_traffic();

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      mismatches++;
      $display("%0d predicted results never arrived", pending_verdicts.size());
    end

    $display("covered %0d items, %0d limit settings: %0d admitted, %0d over, %0d sweeps",
             items_sent, settings_used, n_admitted, n_over, n_sweeps);
    $display("%0d results compared, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS per_client_fixed_window_rate_limiter_unit");
    end else begin
      $display("FAIL per_client_fixed_window_rate_limiter_unit");
    end
    $finish;
  end

endmodule

// ----- per_client_fixed_window_rate_limiter_unit.f -----
+incdir+rtl
rtl/pcfwrl_pkg.sv
rtl/pcfwrl_if.sv
rtl/pcfwrl_datapath.sv
rtl/pcfwrl_ctrl.sv
rtl/per_client_fixed_window_rate_limiter_unit.sv
tb/sv/tb_per_client_fixed_window_rate_limiter_unit.sv
